### hdl/mesh_vertex_normal_averager_top_defines.svh
// Assertion macros shared by the mesh vertex normal averager RTL.
`ifndef MESH_VERTEX_NORMAL_AVERAGER_TOP_DEFINES_SVH
`define MESH_VERTEX_NORMAL_AVERAGER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define MVNA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication check failed");
// Next-cycle implication check.
`define MVNA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication check failed");
`else
`define MVNA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MVNA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/mvna_pkg.sv
// Types and constants shared by the mesh vertex normal averager modules.
`default_nettype none
package mvna_pkg;
	// Field widths.
	localparam int IDX_W = 16;
	localparam int SUM_W = 26;
	localparam int NRM_W = 18;

	// Command codes.
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_TRI   = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	// Command queue size.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;

	// Quotient lengths for the shared divider.
	localparam logic [4:0] TRI_QBITS = 5'd17;
	localparam logic [4:0] QRY_QBITS = 5'd26;

	// One decoded command as it travels through the queue.
	typedef struct packed {
		logic [1:0]       cmd;
		logic [IDX_W-1:0] idx;
		logic [23:0]      pos_x;
		logic [23:0]      pos_y;
		logic [23:0]      pos_z;
		logic [IDX_W-1:0] corner_a;
		logic [IDX_W-1:0] corner_b;
		logic [IDX_W-1:0] corner_c;
	} entry_t;

	// Divider request and response.
	typedef struct packed {
		logic        start;
		logic [47:0] num;
		logic [31:0] den;
		logic [4:0]  nbits;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [25:0] quo;
	} div_rsp_t;

	// Status from the back part to the front part.
	typedef struct packed {
		logic init_busy;
	} back_status_t;
endpackage
`default_nettype wire

### hdl/mesh_vertex_normal_averager_top.sv
// Top level of the mesh vertex normal averager.
//
// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  tuser: cmd; tdata: index, position, corners
// m        out  m_tvalid/m_tready  tuser: unused_vertex; tdata: normal x, y, z
//
// A load is written to the vertex store as it is popped; a triangle passes through the cross
// product on one shared multiplier, the one-bit-per-cycle normalising shift, the 31-step
// square root and three 17-bit divisions in the shared divider.
// A degenerate triangle skips the divisions.
// A query makes three 26-bit divisions in the same divider; an unused vertex makes none.
// A clear sweeps all MAX_VERTICES slots of the accumulator store.
// After reset the same sweep runs with s_tready low.
// A waiting result in the output register stalls only the next query.
`default_nettype none
module mesh_vertex_normal_averager_top #(
	parameter int MAX_VERTICES = 4096,
	parameter int COUNT_BITS   = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [11:0] load_index, [35:12] pos_x, [59:36] pos_y, [83:60] pos_z,
	// [95:84] corner_a, [107:96] corner_b, [119:108] corner_c
	input  wire logic [119:0] s_tdata,
	// [1:0] cmd
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [17:0] normal_x, [35:18] normal_y, [53:36] normal_z, [55:54] zero
	output logic [55:0]       m_tdata,
	// [0] unused_vertex
	output logic [0:0]        m_tuser
);
	mvna_pkg::back_status_t status;
	mvna_pkg::entry_t       push_data;
	mvna_pkg::entry_t       pop_data;
	mvna_pkg::div_req_t     div_req;
	mvna_pkg::div_rsp_t     div_rsp;
	logic                   q_full;
	logic                   q_empty;
	logic                   q_push;
	logic                   q_pop;

	// Front part.
	mvna_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.status   (status),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (push_data)
	);

	// Command queue.
	mvna_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	// Shared divider.
	mvna_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Back part.
	mvna_back #(.MAX_VERTICES(MAX_VERTICES), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_data   (pop_data),
		.status   (status),
		.div_req  (div_req),
		.div_rsp  (div_rsp),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);
endmodule
`default_nettype wire

### hdl/mvna_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module mvna_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### hdl/mvna_queue.sv
// Short command queue between the front and back parts.
`default_nettype none
`include "mesh_vertex_normal_averager_top_defines.svh"
module mvna_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire mvna_pkg::entry_t push_data,
	output logic                  full,
	input  wire logic             pop,
	output mvna_pkg::entry_t      pop_data,
	output logic                  empty
);
	mvna_pkg::entry_t mem_q [mvna_pkg::Q_DEPTH];
	logic [mvna_pkg::Q_PTR_W-1:0] wr_q;
	logic [mvna_pkg::Q_PTR_W-1:0] rd_q;
	logic [mvna_pkg::Q_PTR_W:0]   count_q;

	assign full     = (count_q == (mvna_pkg::Q_PTR_W+1)'(mvna_pkg::Q_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`MVNA_ASSERT_IMP(a_queue_no_overflow, clk, arst_n, push && !pop, !full)
endmodule
`default_nettype wire

### hdl/mvna_front.sv
// Front part: accepts stream words, folds indices into range and feeds the queue.
`default_nettype none
module mvna_front #(
	parameter int MAX_VERTICES = 4096
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [119:0]           s_tdata,
	input  wire logic [1:0]             s_tuser,
	input  wire mvna_pkg::back_status_t status,
	input  wire logic                   q_full,
	output logic                        q_push,
	output mvna_pkg::entry_t            q_data
);
	mvna_pkg::entry_t ent_q;
	mvna_pkg::entry_t ent_d;
	logic             vld_q;
	logic             accept;

	// Reduce a 12-bit index modulo the vertex count by conditional subtraction.
	function automatic logic [mvna_pkg::IDX_W-1:0] fold_index(input logic [11:0] raw);
		logic [31:0] r;
		logic [31:0] lim;
		r = {20'b0, raw};
		for (int k = 7; k >= 0; k--) begin
			lim = 32'(MAX_VERTICES) << k;
			if (r >= lim) begin
				r = r - lim;
			end
		end
		return r[mvna_pkg::IDX_W-1:0];
	endfunction

	// Decode the incoming word.
	always_comb begin
		ent_d.cmd      = s_tuser;
		ent_d.idx      = fold_index(s_tdata[11:0]);
		ent_d.pos_x    = s_tdata[35:12];
		ent_d.pos_y    = s_tdata[59:36];
		ent_d.pos_z    = s_tdata[83:60];
		ent_d.corner_a = fold_index(s_tdata[95:84]);
		ent_d.corner_b = fold_index(s_tdata[107:96]);
		ent_d.corner_c = fold_index(s_tdata[119:108]);
	end

	assign s_tready = (!vld_q || !q_full) && !status.init_busy;
	assign accept   = s_tvalid && s_tready;
	assign q_push   = vld_q && !q_full;
	assign q_data   = ent_q;

	// Holding register in front of the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (accept) begin
			vld_q <= 1'b1;
		end else if (q_push) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_q <= ent_d;
		end
	end
endmodule
`default_nettype wire

### hdl/mvna_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module mvna_divider (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mvna_pkg::div_req_t req,
	output mvna_pkg::div_rsp_t      rsp
);
	logic        busy_q;
	logic        done_q;
	logic [47:0] rem_q;
	logic [31:0] den_q;
	logic [4:0]  k_q;
	logic [25:0] quo_q;
	logic [47:0] cand;

	assign cand     = {16'b0, den_q} << k_q;
	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
			end else if (busy_q && k_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: compare the remainder with the shifted divisor.
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= req.num;
			den_q <= req.den;
			k_q   <= req.nbits - 5'd1;
			quo_q <= '0;
		end else if (busy_q) begin
			if (rem_q >= cand) begin
				rem_q      <= rem_q - cand;
				quo_q[k_q] <= 1'b1;
			end
			k_q <= k_q - 5'd1;
		end
	end
endmodule
`default_nettype wire

### hdl/mvna_back.sv
// Back part: command sequencer with vertex and accumulator stores.
`default_nettype none
`include "mesh_vertex_normal_averager_top_defines.svh"
module mvna_back #(
	parameter int MAX_VERTICES = 4096,
	parameter int COUNT_BITS   = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_empty,
	output logic                    q_pop,
	input  wire mvna_pkg::entry_t   q_data,
	output mvna_pkg::back_status_t  status,
	output mvna_pkg::div_req_t      div_req,
	input  wire mvna_pkg::div_rsp_t div_rsp,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [55:0]             m_tdata,
	output logic [0:0]              m_tuser
);
	localparam int IW    = $clog2(MAX_VERTICES);
	localparam int SW    = mvna_pkg::SUM_W;
	localparam int NW    = mvna_pkg::NRM_W;
	localparam int ACC_W = 3 * SW + COUNT_BITS;
	localparam logic [IW-1:0]         LAST_SLOT = IW'(MAX_VERTICES - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic signed [SW-1:0]  SUM_MAX   = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0]  SUM_MIN   = {1'b1, {(SW-1){1'b0}}};

	// Sequencer states.
	localparam logic [4:0] ST_INIT  = 5'd0;
	localparam logic [4:0] ST_IDLE  = 5'd1;
	localparam logic [4:0] ST_RQ    = 5'd2;
	localparam logic [4:0] ST_RR    = 5'd3;
	localparam logic [4:0] ST_RW    = 5'd4;
	localparam logic [4:0] ST_CROSS = 5'd5;
	localparam logic [4:0] ST_SCALE = 5'd6;
	localparam logic [4:0] ST_SQ    = 5'd7;
	localparam logic [4:0] ST_SQRT  = 5'd8;
	localparam logic [4:0] ST_TGO   = 5'd9;
	localparam logic [4:0] ST_TWT   = 5'd10;
	localparam logic [4:0] ST_CRD   = 5'd11;
	localparam logic [4:0] ST_CUPD  = 5'd12;
	localparam logic [4:0] ST_QCHK  = 5'd13;
	localparam logic [4:0] ST_QGO   = 5'd14;
	localparam logic [4:0] ST_QWT   = 5'd15;
	localparam logic [4:0] ST_OUT   = 5'd16;

	logic [4:0]              state_q;
	logic                    init_q;
	logic [IW-1:0]           clr_q;
	mvna_pkg::entry_t        ent_q;
	logic [71:0]             pos_p_q;
	logic signed [24:0]      u_q [3];
	logic signed [24:0]      w_q [3];
	logic [2:0]              step_q;
	logic signed [50:0]      c_q [3];
	logic [50:0]             t_q [3];
	logic [2:0]              neg_q;
	logic [61:0]             sum_q;
	logic [61:0]             root_q;
	logic [4:0]              sqk_q;
	logic [1:0]              ci_q;
	logic [NW-1:0]           nrm_q [3];
	logic                    unused_q;
	logic [ACC_W-1:0]        acc_q;
	logic signed [61:0]      prod_s1;
	logic                    out_vld_q;
	logic [55:0]             out_data_q;
	logic                    out_user_q;

	logic                    vtx_we;
	logic [IW-1:0]           vtx_raddr;
	logic [71:0]             vtx_rdata;
	logic                    acc_we;
	logic [IW-1:0]           acc_waddr;
	logic [ACC_W-1:0]        acc_wdata;
	logic [IW-1:0]           acc_raddr;
	logic [ACC_W-1:0]        acc_rdata;
	logic signed [30:0]      mul_a;
	logic signed [30:0]      mul_b;
	logic [61:0]             sq_bit;
	logic [61:0]             sq_try;
	logic [30:0]             len;
	logic [50:0]             t_sel;
	logic                    neg_sel;
	logic [mvna_pkg::IDX_W-1:0] corner_sel;
	logic [SW-1:0]           qsum_sel;
	logic [SW-1:0]           qmag;
	logic [COUNT_BITS-1:0]   acc_cnt;
	logic [COUNT_BITS-1:0]   q_cnt;
	logic                    div_neg;
	logic [25:0]             div_signed;
	logic                    out_load;

	// Signed difference of two Q7.16 coordinates.
	function automatic logic signed [24:0] diff(input logic [23:0] a, input logic [23:0] b);
		return $signed({a[23], a}) - $signed({b[23], b});
	endfunction

	// Accumulator update clamped to the signed sum range.
	function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s, input logic [NW-1:0] n);
		logic [SW:0] r;
		r = {s[SW-1], s} + {{(SW+1-NW){n[NW-1]}}, n};
		if (r[SW] != r[SW-1]) begin
			return r[SW] ? SUM_MIN : SUM_MAX;
		end
		return r[SW-1:0];
	endfunction

	// Stores: positions {z, y, x}; accumulators {count, sum z, sum y, sum x}.
	mvna_ram #(.WIDTH(72), .DEPTH(MAX_VERTICES)) u_vtx_ram (
		.clk   (clk),
		.we    (vtx_we),
		.waddr (q_data.idx[IW-1:0]),
		.wdata ({q_data.pos_z, q_data.pos_y, q_data.pos_x}),
		.raddr (vtx_raddr),
		.rdata (vtx_rdata)
	);

	mvna_ram #(.WIDTH(ACC_W), .DEPTH(MAX_VERTICES)) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.raddr (acc_raddr),
		.rdata (acc_rdata)
	);

	assign q_pop            = (state_q == ST_IDLE) && !q_empty;
	assign vtx_we           = q_pop && (q_data.cmd == mvna_pkg::CMD_LOAD);
	assign status.init_busy = init_q;
	assign len              = root_q[30:0];
	assign acc_cnt          = acc_rdata[ACC_W-1:3*SW];
	assign q_cnt            = acc_q[ACC_W-1:3*SW];
	assign out_load         = (state_q == ST_OUT) && (!out_vld_q || m_tready);

	// Per-component and per-corner selections.
	always_comb begin
		unique case (ci_q)
			2'd0: begin
				t_sel      = t_q[0];
				neg_sel    = neg_q[0];
				corner_sel = ent_q.corner_a;
				qsum_sel   = acc_q[SW-1:0];
			end
			2'd1: begin
				t_sel      = t_q[1];
				neg_sel    = neg_q[1];
				corner_sel = ent_q.corner_b;
				qsum_sel   = acc_q[2*SW-1:SW];
			end
			default: begin
				t_sel      = t_q[2];
				neg_sel    = neg_q[2];
				corner_sel = ent_q.corner_c;
				qsum_sel   = acc_q[3*SW-1:2*SW];
			end
		endcase
		qmag       = qsum_sel[SW-1] ? (~qsum_sel + 1'b1) : qsum_sel;
		div_neg    = (state_q == ST_TWT) ? neg_sel : qsum_sel[SW-1];
		div_signed = div_neg ? (~div_rsp.quo + 1'b1) : div_rsp.quo;
	end

	// Shared multiplier operands: cross product terms, then squares.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_CROSS) begin
			unique case (step_q)
				3'd0: begin mul_a = 31'(u_q[1]); mul_b = 31'(w_q[2]); end
				3'd1: begin mul_a = 31'(u_q[2]); mul_b = 31'(w_q[1]); end
				3'd2: begin mul_a = 31'(u_q[2]); mul_b = 31'(w_q[0]); end
				3'd3: begin mul_a = 31'(u_q[0]); mul_b = 31'(w_q[2]); end
				3'd4: begin mul_a = 31'(u_q[0]); mul_b = 31'(w_q[1]); end
				3'd5: begin mul_a = 31'(u_q[1]); mul_b = 31'(w_q[0]); end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end else if (state_q == ST_SQ) begin
			unique case (step_q)
				3'd0: begin
					mul_a = $signed({1'b0, t_q[0][29:0]});
					mul_b = $signed({1'b0, t_q[0][29:0]});
				end
				3'd1: begin
					mul_a = $signed({1'b0, t_q[1][29:0]});
					mul_b = $signed({1'b0, t_q[1][29:0]});
				end
				3'd2: begin
					mul_a = $signed({1'b0, t_q[2][29:0]});
					mul_b = $signed({1'b0, t_q[2][29:0]});
				end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	// Square root digit step.
	always_comb begin
		sq_bit = 62'(1) << {sqk_q, 1'b0};
		sq_try = root_q + sq_bit;
	end

	// Store addressing.
	always_comb begin
		vtx_raddr = ent_q.corner_b[IW-1:0];
		if (state_q == ST_IDLE) begin
			vtx_raddr = q_data.corner_a[IW-1:0];
		end else if (state_q == ST_RR) begin
			vtx_raddr = ent_q.corner_c[IW-1:0];
		end
		acc_raddr = (state_q == ST_IDLE) ? q_data.idx[IW-1:0] : corner_sel[IW-1:0];
		acc_we    = 1'b0;
		acc_waddr = corner_sel[IW-1:0];
		acc_wdata = {acc_cnt + 1'b1,
			sat_add(acc_rdata[3*SW-1:2*SW], nrm_q[2]),
			sat_add(acc_rdata[2*SW-1:SW], nrm_q[1]),
			sat_add(acc_rdata[SW-1:0], nrm_q[0])};
		if (state_q == ST_INIT) begin
			acc_we    = 1'b1;
			acc_waddr = clr_q;
			acc_wdata = '0;
		end else if (state_q == ST_CUPD) begin
			acc_we = (acc_cnt != COUNT_MAX);
		end
	end

	// Divider requests.
	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = 48'({t_sel[29:0], 16'b0}) + 48'(len[30:1]);
		div_req.den   = 32'(len);
		div_req.nbits = mvna_pkg::TRI_QBITS;
		if (state_q == ST_TGO) begin
			div_req.start = (len != '0);
		end else if (state_q == ST_QGO) begin
			div_req.start = 1'b1;
			div_req.num   = 48'(qmag) + 48'(q_cnt >> 1);
			div_req.den   = 32'(q_cnt);
			div_req.nbits = mvna_pkg::QRY_QBITS;
		end
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			init_q  <= 1'b1;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					if (clr_q == LAST_SLOT) begin
						state_q <= ST_IDLE;
						init_q  <= 1'b0;
					end
					clr_q <= clr_q + 1'b1;
				end
				ST_IDLE: begin
					clr_q <= '0;
					if (!q_empty) begin
						unique case (q_data.cmd)
							mvna_pkg::CMD_LOAD:  state_q <= ST_IDLE;
							mvna_pkg::CMD_TRI:   state_q <= ST_RQ;
							mvna_pkg::CMD_QUERY: state_q <= ST_QCHK;
							default:             state_q <= ST_INIT;
						endcase
					end
				end
				ST_RQ:    state_q <= ST_RR;
				ST_RR:    state_q <= ST_RW;
				ST_RW:    state_q <= ST_CROSS;
				ST_CROSS: if (step_q == 3'd7) state_q <= ST_SCALE;
				ST_SCALE: begin
					if (t_q[0][50:30] == '0 && t_q[1][50:30] == '0 && t_q[2][50:30] == '0) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ:    if (step_q == 3'd3) state_q <= ST_SQRT;
				ST_SQRT:  if (sqk_q == '0) state_q <= ST_TGO;
				ST_TGO:   state_q <= (len == '0) ? ST_CRD : ST_TWT;
				ST_TWT: begin
					if (div_rsp.done) begin
						state_q <= (ci_q == 2'd2) ? ST_CRD : ST_TGO;
					end
				end
				ST_CRD:   state_q <= ST_CUPD;
				ST_CUPD:  state_q <= (ci_q == 2'd2) ? ST_IDLE : ST_CRD;
				ST_QCHK:  state_q <= (acc_cnt == '0) ? ST_OUT : ST_QGO;
				ST_QGO:   state_q <= ST_QWT;
				ST_QWT: begin
					if (div_rsp.done) begin
						state_q <= (ci_q == 2'd2) ? ST_OUT : ST_QGO;
					end
				end
				ST_OUT:   if (out_load) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Sequencer datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ent_q  <= q_data;
				step_q <= '0;
				ci_q   <= '0;
				for (int i = 0; i < 3; i++) begin
					nrm_q[i] <= '0;
				end
			end
			ST_RQ: pos_p_q <= vtx_rdata;
			ST_RR: begin
				u_q[0] <= diff(vtx_rdata[23:0], pos_p_q[23:0]);
				u_q[1] <= diff(vtx_rdata[47:24], pos_p_q[47:24]);
				u_q[2] <= diff(vtx_rdata[71:48], pos_p_q[71:48]);
			end
			ST_RW: begin
				w_q[0] <= diff(vtx_rdata[23:0], pos_p_q[23:0]);
				w_q[1] <= diff(vtx_rdata[47:24], pos_p_q[47:24]);
				w_q[2] <= diff(vtx_rdata[71:48], pos_p_q[71:48]);
			end
			ST_CROSS: begin
				// The product of the previous step lands in its component.
				unique case (step_q)
					3'd1: c_q[0] <= prod_s1[50:0];
					3'd2: c_q[0] <= c_q[0] - $signed(prod_s1[50:0]);
					3'd3: c_q[1] <= prod_s1[50:0];
					3'd4: c_q[1] <= c_q[1] - $signed(prod_s1[50:0]);
					3'd5: c_q[2] <= prod_s1[50:0];
					3'd6: c_q[2] <= c_q[2] - $signed(prod_s1[50:0]);
					3'd7: begin
						for (int i = 0; i < 3; i++) begin
							neg_q[i] <= c_q[i][50];
							t_q[i]   <= c_q[i][50] ? 51'(-c_q[i]) : 51'(c_q[i]);
						end
					end
					default: ;
				endcase
				step_q <= (step_q == 3'd7) ? 3'd0 : step_q + 3'd1;
			end
			ST_SCALE: begin
				if (!(t_q[0][50:30] == '0 && t_q[1][50:30] == '0 && t_q[2][50:30] == '0)) begin
					for (int i = 0; i < 3; i++) begin
						t_q[i] <= t_q[i] >> 1;
					end
				end
			end
			ST_SQ: begin
				unique case (step_q)
					3'd1:    sum_q <= prod_s1;
					3'd2:    sum_q <= sum_q + prod_s1;
					3'd3:    sum_q <= sum_q + prod_s1;
					default: ;
				endcase
				root_q <= '0;
				sqk_q  <= 5'd30;
				step_q <= step_q + 3'd1;
			end
			ST_SQRT: begin
				if (sum_q >= sq_try) begin
					sum_q  <= sum_q - sq_try;
					root_q <= (root_q >> 1) + sq_bit;
				end else begin
					root_q <= root_q >> 1;
				end
				sqk_q <= sqk_q - 5'd1;
			end
			ST_TWT, ST_QWT: begin
				if (div_rsp.done) begin
					unique case (ci_q)
						2'd0:    nrm_q[0] <= div_signed[NW-1:0];
						2'd1:    nrm_q[1] <= div_signed[NW-1:0];
						default: nrm_q[2] <= div_signed[NW-1:0];
					endcase
					ci_q <= (ci_q == 2'd2) ? 2'd0 : ci_q + 2'd1;
				end
			end
			ST_CUPD: ci_q <= ci_q + 2'd1;
			ST_QCHK: begin
				acc_q    <= acc_rdata;
				unused_q <= (acc_cnt == '0);
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {2'b0, nrm_q[2], nrm_q[1], nrm_q[0]};
			out_user_q <= unused_q;
		end
	end

	assign m_tvalid   = out_vld_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_user_q;

	`MVNA_ASSERT_IMP(a_div_start_idle, clk, arst_n, div_req.start, !div_rsp.busy)
	`MVNA_ASSERT_IMP(a_init_in_sweep, clk, arst_n, init_q, state_q == ST_INIT)
	`MVNA_ASSERT_NEXT(a_tri_to_corners, clk, arst_n, state_q == ST_TWT && div_rsp.done && ci_q == 2'd2, state_q == ST_CRD)
endmodule
`default_nettype wire
